[rtl/lz77_pkg.sv]
// Package for the LZ77 token decompressor: parse phases, error codes, sizes.
// No dependencies.
`default_nettype none
package lz77_pkg;
   localparam int WINDOW_DEPTH_DEF = 8192;
   localparam int OUTPUT_LANES_DEF = 8;
   localparam logic [7:0] OFFSET_HIGH_MASK = 8'h1f;
   localparam logic [2:0] LONG_CODE = 3'd7;
   localparam int LONG_BASE = 9;
   localparam int SHORT_BASE = 2;

   typedef enum logic [1:0] {
      PH_TOKEN   = 2'd0,
      PH_LITERAL = 2'd1,
      PH_OFFLOW  = 2'd2,
      PH_LENGTH  = 2'd3
   } phase_type;

   typedef enum logic [1:0] {
      ERR_NONE     = 2'd0,
      ERR_DISTANCE = 2'd1,
      ERR_TRUNC    = 2'd2
   } err_type;

   // controller -> datapath
   typedef struct packed {
      logic       load;        // take an input byte
      logic       load_off_hi; // take the high offset bits of a token byte
      logic       put_lit;     // write the held byte as a literal
      logic       copy_start;  // start copy: set read pointer
      logic       copy_read;   // issue history read
      logic       put_copy;    // write byte read last cycle
      logic       emit;        // hand group to output register
      logic       emit_err;    // emit error result
      err_type    err;
      logic       last;
      logic       frame_clr;   // clear history count
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic       dist_bad;
      logic       group_full;
      logic       group_empty;
      logic       out_busy;
   } sts_type;
endpackage
`default_nettype wire

[rtl/lz77_ram.sv]
// Generic single write, single read RAM with registered read data.
// No dependencies.
`default_nettype none
module lz77_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8192
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

[rtl/lz77_datapath.sv]
// Datapath: held token fields, history RAM, pointers, lane packer, output register.
// Depends on lz77_pkg and lz77_ram.
`default_nettype none
module lz77_datapath
   import lz77_pkg::*;
#(
   parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF,
   parameter int OUTPUT_LANES = OUTPUT_LANES_DEF
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire cmd_type    cmd,
   input  wire logic [7:0] in_byte,
   output sts_type         sts,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [7:0]      lane_out [OUTPUT_LANES],
   output logic [3:0]      count_out,
   output logic            last_out,
   output logic [1:0]      err_out
);
   localparam int AW = $clog2(WINDOW_DEPTH);
   localparam int CW = AW + 1;
   localparam int LW = (OUTPUT_LANES > 1) ? $clog2(OUTPUT_LANES) : 1;

   logic [7:0]    byte_ff;
   logic [12:0]   off_ff, off_in;
   logic [AW-1:0] wp_ff, rp_ff, rd_addr;
   logic [CW-1:0] dec_ff;
   logic [7:0]    grp_ff [OUTPUT_LANES];
   logic [LW-1:0] grp_idx;
   logic [3:0]    fill_ff;
   logic          ov_ff;
   logic [7:0]    ob_ff [OUTPUT_LANES];
   logic [3:0]    oc_ff;
   logic          ol_ff;
   logic [1:0]    oe_ff;
   logic [7:0]    ram_q, rd_data, wr_data;
   logic          byp_ff;
   logic [7:0]    byp_byte_ff;
   logic          wr_en;
   logic [CW-1:0] distance;

   assign wr_en    = cmd.put_lit | cmd.put_copy;
   assign wr_data  = cmd.put_copy ? rd_data : byte_ff;
   assign distance = CW'(off_ff) + CW'(1);
   // a stalled copy re-reads the pending address
   assign rd_addr  = cmd.copy_read ? rp_ff : rp_ff - AW'(1);
   // read of the address written in the same cycle takes the written byte
   assign rd_data  = byp_ff ? byp_byte_ff : ram_q;
   assign grp_idx  = cmd.emit ? '0 : LW'(fill_ff);

   lz77_ram #(.WIDTH(8), .DEPTH(WINDOW_DEPTH)) u_hist (
      .clock(clock), .wr_en(wr_en), .wr_addr(wp_ff), .wr_data(wr_data),
      .rd_addr(rd_addr), .rd_data(ram_q));

   always_comb begin
      off_in = off_ff;
      if (cmd.load) off_in[7:0] = in_byte;
      if (cmd.load_off_hi) off_in[12:8] = in_byte[4:0] & OFFSET_HIGH_MASK[4:0];
   end

   always_ff @(posedge clock) begin
      if (cmd.load) byte_ff <= in_byte;
      off_ff <= off_in;
      if (cmd.copy_start) rp_ff <= wp_ff - AW'(distance);
      else if (cmd.copy_read) rp_ff <= rp_ff + AW'(1);
      if (wr_en) grp_ff[grp_idx] <= wr_data;
      byp_ff <= wr_en && (rd_addr == wp_ff);
      byp_byte_ff <= wr_data;
      if (reset) begin
         wp_ff <= '0; dec_ff <= '0; fill_ff <= '0; ov_ff <= 1'b0;
      end else begin
         if (wr_en) wp_ff <= wp_ff + AW'(1);
         if (cmd.frame_clr) dec_ff <= '0;
         else if (wr_en && dec_ff < CW'(WINDOW_DEPTH)) dec_ff <= dec_ff + CW'(1);
         if (cmd.emit || cmd.emit_err) begin
            ov_ff <= 1'b1;
            for (int i = 0; i < OUTPUT_LANES; i++)
               ob_ff[i] <= (cmd.emit && 4'(i) < fill_ff) ? grp_ff[i] : 8'd0;
            oc_ff <= cmd.emit ? fill_ff : 4'd0;
            ol_ff <= cmd.last;
            oe_ff <= cmd.emit ? ERR_NONE : cmd.err;
         end else if (ov_ff && rsp_ready) ov_ff <= 1'b0;
         if (cmd.emit) fill_ff <= wr_en ? 4'd1 : 4'd0;
         else if (wr_en) fill_ff <= fill_ff + 4'd1;
      end
   end

   assign sts.dist_bad    = distance > dec_ff;
   assign sts.group_full  = fill_ff == 4'(OUTPUT_LANES);
   assign sts.group_empty = fill_ff == 4'd0;
   assign sts.out_busy    = ov_ff & ~rsp_ready;
   assign rsp_valid = ov_ff;
   assign lane_out  = ob_ff;
   assign count_out = oc_ff;
   assign last_out  = ol_ff;
   assign err_out   = oe_ff;
endmodule
`default_nettype wire

[rtl/lz77_ctrl.sv]
// Controller: token parser and copy sequencer.
// Depends on lz77_pkg.
`default_nettype none
module lz77_ctrl
   import lz77_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [7:0] req_data_byte,
   input  wire logic       req_frame_end,
   input  wire sts_type    sts,
   output cmd_type         cmd
);
   typedef enum logic [2:0] {
      S_IDLE, S_LIT, S_CHECK, S_COPY, S_FLUSH, S_TRUNC
   } state_type;

   state_type state_ff, state_in;
   phase_type ph_ff, ph_in;
   logic [2:0] len_code_ff, len_code_in;
   logic [5:0] lit_ff, lit_in;
   logic [8:0] left_ff, left_in;   // bytes still to read
   logic       pend_ff, pend_in;   // read data arriving this cycle
   logic       fend_ff, fend_in;
   logic       trunc_ff, trunc_in;

   always_comb begin
      state_in = state_ff; ph_in = ph_ff; len_code_in = len_code_ff;
      lit_in = lit_ff; left_in = left_ff; pend_in = 1'b0;
      fend_in = fend_ff; trunc_in = trunc_ff;
      cmd = '0;
      req_ready = (state_ff == S_IDLE);
      unique case (state_ff)
         S_IDLE: if (req_valid) begin
            cmd.load = 1'b1;
            fend_in = req_frame_end;
            trunc_in = 1'b0;
            unique case (ph_ff)
               PH_TOKEN: begin
                  if (req_data_byte[7:5] == 3'd0) begin
                     lit_in = 6'({1'b0, req_data_byte[4:0]}) + 6'd1;
                     ph_in = PH_LITERAL;
                  end else begin
                     len_code_in = req_data_byte[7:5];
                     cmd.load_off_hi = 1'b1;
                     ph_in = PH_OFFLOW;
                  end
                  state_in = S_FLUSH;
                  trunc_in = req_frame_end;
               end
               PH_LITERAL: begin
                  lit_in = lit_ff - 6'd1;
                  ph_in = (lit_ff == 6'd1) ? PH_TOKEN : PH_LITERAL;
                  trunc_in = req_frame_end && lit_ff != 6'd1;
                  state_in = S_LIT;
               end
               PH_OFFLOW: begin
                  if (len_code_ff == LONG_CODE) begin
                     ph_in = PH_LENGTH;
                     state_in = S_FLUSH;
                     trunc_in = req_frame_end;
                  end else begin
                     ph_in = PH_TOKEN;
                     left_in = 9'(len_code_ff) + 9'(SHORT_BASE);
                     state_in = S_CHECK;
                  end
               end
               default: begin
                  ph_in = PH_TOKEN;
                  left_in = 9'(req_data_byte) + 9'(LONG_BASE);
                  state_in = S_CHECK;
               end
            endcase
            if (req_frame_end) ph_in = PH_TOKEN;
            if (ph_ff == PH_LENGTH) cmd.load = 1'b0;
         end
         S_LIT: if (!sts.out_busy || !sts.group_full) begin
            if (sts.group_full) begin
               cmd.emit = 1'b1;
            end
            cmd.put_lit = 1'b1;
            state_in = S_FLUSH;
         end
         S_CHECK: if (!sts.out_busy) begin
            if (sts.dist_bad) begin
               cmd.emit_err = 1'b1; cmd.err = ERR_DISTANCE; cmd.last = ~trunc_ff;
               state_in = trunc_ff ? S_TRUNC : S_IDLE;
               cmd.frame_clr = fend_ff;
            end else begin
               cmd.copy_start = 1'b1;
               state_in = S_COPY;
            end
         end
         S_COPY: begin
            if (pend_ff) begin
               if (sts.group_full) begin
                  if (sts.out_busy) begin
                     // hold: re-read the same byte next cycle
                     state_in = S_COPY;
                  end else begin
                     cmd.emit = 1'b1; cmd.put_copy = 1'b1;
                  end
               end else cmd.put_copy = 1'b1;
            end
            if (pend_ff && !cmd.put_copy) begin
               // stalled: rewind one address
               cmd.copy_start = 1'b0;
            end
            if (left_ff != 9'd0 && (!pend_ff || cmd.put_copy)) begin
               cmd.copy_read = 1'b1; pend_in = 1'b1; left_in = left_ff - 9'd1;
            end else if (pend_ff && !cmd.put_copy) begin
               pend_in = 1'b1;
            end
            if (left_ff == 9'd0 && (!pend_ff || cmd.put_copy)) state_in = S_FLUSH;
         end
         S_FLUSH: if (!sts.out_busy) begin
            if (!sts.group_empty) begin
               cmd.emit = 1'b1; cmd.last = ~trunc_ff;
            end
            state_in = trunc_ff ? S_TRUNC : S_IDLE;
            if (!trunc_ff) cmd.frame_clr = fend_ff;
         end
         S_TRUNC: if (!sts.out_busy) begin
            cmd.emit_err = 1'b1; cmd.err = ERR_TRUNC; cmd.last = 1'b1;
            cmd.frame_clr = 1'b1; state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; ph_ff <= PH_TOKEN; len_code_ff <= '0; lit_ff <= '0;
         left_ff <= '0; pend_ff <= 1'b0; fend_ff <= 1'b0; trunc_ff <= 1'b0;
      end else begin
         state_ff <= state_in; ph_ff <= ph_in; len_code_ff <= len_code_in;
         lit_ff <= req_valid && req_frame_end && state_ff == S_IDLE ? 6'd0 : lit_in;
         left_ff <= left_in; pend_ff <= pend_in; fend_ff <= fend_in;
         trunc_ff <= trunc_in;
      end
   end
endmodule
`default_nettype wire

[rtl/lz77_token_decompressor.sv]
// Top level of the LZ77 token decompressor: controller plus datapath.
// Depends on lz77_pkg, lz77_ctrl, lz77_datapath, lz77_ram.
// channel | ports                                          | handshake
// req     | data_byte, frame_end                           | req_valid / req_ready
// rsp     | out_byte0..7, byte_count, run_last, error_code | rsp_valid / rsp_ready
// Bytes are taken only in idle; a token byte then passes flush, a literal write
// and flush, a copy's last byte check, copy and flush, a distance error check
// only; a truncated token adds an error state. The single history read port sets
// the copy rate of one byte a cycle when not stalled. Reset is synchronous; the
// history RAM is not cleared. A stalled result register holds the sequencer.
`default_nettype none
module lz77_token_decompressor
   import lz77_pkg::*;
#(
   parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF,
   parameter int OUTPUT_LANES = OUTPUT_LANES_DEF
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [7:0] req_data_byte,
   input  wire logic       req_frame_end,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [7:0]      rsp_out_byte0, rsp_out_byte1, rsp_out_byte2, rsp_out_byte3,
   output logic [7:0]      rsp_out_byte4, rsp_out_byte5, rsp_out_byte6, rsp_out_byte7,
   output logic [3:0]      rsp_byte_count,
   output logic            rsp_run_last,
   output logic [1:0]      rsp_error_code
);
   cmd_type cmd;
   sts_type sts;
   logic [7:0] lanes [OUTPUT_LANES];
   logic [7:0] b [8];

   lz77_ctrl u_ctrl (.clock, .reset, .req_valid, .req_ready, .req_data_byte,
      .req_frame_end, .sts, .cmd);
   lz77_datapath #(.WINDOW_DEPTH(WINDOW_DEPTH), .OUTPUT_LANES(OUTPUT_LANES)) u_dp (
      .clock, .reset, .cmd, .in_byte(req_data_byte), .sts,
      .rsp_valid, .rsp_ready, .lane_out(lanes), .count_out(rsp_byte_count),
      .last_out(rsp_run_last), .err_out(rsp_error_code));

   always_comb
      for (int i = 0; i < 8; i++) b[i] = (i < OUTPUT_LANES) ? lanes[i] : 8'd0;
   assign rsp_out_byte0 = b[0]; assign rsp_out_byte1 = b[1];
   assign rsp_out_byte2 = b[2]; assign rsp_out_byte3 = b[3];
   assign rsp_out_byte4 = b[4]; assign rsp_out_byte5 = b[5];
   assign rsp_out_byte6 = b[6]; assign rsp_out_byte7 = b[7];

`ifndef SYNTHESIS
   a_err_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error_code != ERR_NONE |-> rsp_byte_count == 4'd0)
      else $error("error result carries bytes");
   a_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_byte_count <= 4'(OUTPUT_LANES))
      else $error("byte count beyond lanes");
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !(cmd.put_copy || cmd.put_lit))
      else $error("history write while idle");
`endif
endmodule
`default_nettype wire

[test/tb.sv]
// Testbench for lz77_token_decompressor: drives compressed items, predicts the
// decoded groups with a behavioural model and checks every result item.
// Depends on lz77_pkg and the RTL of the decompressor.
`timescale 1ns / 1ps
module tb
   import lz77_pkg::*;
();

   localparam int WIN = 8192;
   localparam int LANES = 8;
   localparam int STALL_LIMIT = 20000;
   localparam int HOLD_CYCLES = 300;

   typedef struct {
      logic [7:0] bytes [LANES];
      logic [3:0] count;
      logic       last;
      err_type    err;
   } group_type;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_ready;
   logic [7:0] req_data_byte = 0;
   logic req_frame_end = 0;
   logic rsp_valid;
   logic rsp_ready = 0;
   logic [7:0] ob [LANES];
   logic [3:0] rsp_byte_count;
   logic rsp_run_last;
   logic [1:0] rsp_error_code;

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   lz77_token_decompressor dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_data_byte(req_data_byte), .req_frame_end(req_frame_end),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_out_byte0(ob[0]), .rsp_out_byte1(ob[1]), .rsp_out_byte2(ob[2]),
      .rsp_out_byte3(ob[3]), .rsp_out_byte4(ob[4]), .rsp_out_byte5(ob[5]),
      .rsp_out_byte6(ob[6]), .rsp_out_byte7(ob[7]),
      .rsp_byte_count(rsp_byte_count), .rsp_run_last(rsp_run_last),
      .rsp_error_code(rsp_error_code)
   );

   // decoder model state
   logic [7:0]  hist [WIN];
   logic [12:0] wr_ptr;
   int          decoded;
   phase_type   phase;
   logic [2:0]  len_code;
   logic [4:0]  off_hi;
   logic [7:0]  off_lo;
   int          lits_left;

   group_type expected_groups [$];
   group_type cur_grp;
   int     fill;
   int     n_new;

   int  mismatches = 0;
   int  idle_cycles = 0;
   bit  timed_out = 0;
   bit  hold_req = 0;
   bit  hold_rsp = 0;
   int  rsp_gap = 0;

   function automatic group_type blank_group();
      group_type g;
      foreach (g.bytes[i]) g.bytes[i] = 8'd0;
      g.count = 0;
      g.last = 0;
      g.err = ERR_NONE;
      return g;
   endfunction

   function automatic void flush_group();
      if (fill > 0) begin
         expected_groups.push_back(cur_grp);
         n_new++;
         fill = 0;
         cur_grp = blank_group();
      end
   endfunction

   function automatic void emit_byte(logic [7:0] b);
      hist[wr_ptr] = b;
      wr_ptr = wr_ptr + 13'd1;
      if (decoded < WIN) decoded++;
      cur_grp.bytes[fill] = b;
      fill++;
      cur_grp.count = 4'(fill);
      if (fill == LANES) flush_group();
   endfunction

   function automatic void emit_error(err_type e);
      group_type g;
      flush_group();
      g = blank_group();
      g.err = e;
      expected_groups.push_back(g);
      n_new++;
   endfunction

   function automatic void copy_back(int len);
      int distance;
      logic [12:0] rd;
      distance = int'(off_hi) * 256 + int'(off_lo) + 1;
      if (distance > decoded) begin
         emit_error(ERR_DISTANCE);
         return;
      end
      rd = wr_ptr - 13'(distance);
      for (int i = 0; i < len; i++) begin
         emit_byte(hist[rd]);
         rd = rd + 13'd1;
      end
   endfunction

   function automatic void decode_item(logic [7:0] b, logic fe);
      n_new = 0;
      fill = 0;
      cur_grp = blank_group();
      case (phase)
         PH_TOKEN: begin
            if (b[7:5] == 3'd0) begin
               lits_left = int'(b[4:0]) + 1;
               phase = PH_LITERAL;
            end else begin
               len_code = b[7:5];
               off_hi = b[4:0];
               phase = PH_OFFLOW;
            end
         end
         PH_LITERAL: begin
            emit_byte(b);
            if (lits_left > 0) lits_left--;
            if (lits_left == 0) phase = PH_TOKEN;
         end
         PH_OFFLOW: begin
            off_lo = b;
            if (len_code == LONG_CODE) begin
               phase = PH_LENGTH;
            end else begin
               phase = PH_TOKEN;
               copy_back(int'(len_code) + SHORT_BASE);
            end
         end
         default: begin
            phase = PH_TOKEN;
            copy_back(LONG_BASE + int'(b));
         end
      endcase
      flush_group();
      if (fe) begin
         if (phase != PH_TOKEN) emit_error(ERR_TRUNC);
         phase = PH_TOKEN;
         lits_left = 0;
         decoded = 0;
      end
      if (n_new > 0) expected_groups[$].last = 1;
   endfunction

   task automatic send_item(logic [7:0] b, logic fe);
      int gap;
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1;
      req_data_byte <= b;
      req_frame_end <= fe;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      decode_item(b, fe);
   endtask

   task automatic wait_drained();
      req_valid <= 0;
      @(posedge clock);
      while (expected_groups.size() != 0 && !timed_out) @(posedge clock);
   endtask

   task automatic send_literals(int n, bit fe);
      send_item(8'(n - 1), 1'b0);
      for (int i = 0; i < n; i++) send_item(8'($urandom), fe && i == n - 1);
   endtask

   task automatic send_copy(int code, int distance, int long_len, bit fe);
      int d;
      d = distance - 1;
      send_item({3'(code), 5'(d >> 8)}, 1'b0);
      if (code == 7) begin
         send_item(8'(d), 1'b0);
         send_item(8'(long_len), fe);
      end else begin
         send_item(8'(d), fe);
      end
   endtask

   task automatic test_directed();
      send_literals(1, 1'b0);
      send_literals(32, 1'b0);
      send_copy(1, 1, 0, 1'b0);          // overlapping, shortest
      send_copy(6, 33, 0, 1'b0);
      send_copy(7, 8, 0, 1'b0);
      send_copy(7, 2, 255, 1'b0);        // longest copy
      send_copy(3, 8192, 0, 1'b0);       // distance too far
      send_item(8'hff, 1'b0);
      send_item(8'hff, 1'b0);
      send_item(8'h00, 1'b1);            // long copy at frame end
      send_item(8'h05, 1'b0);
      send_item(8'haa, 1'b1);            // literal run cut short
      send_item(8'he0, 1'b1);            // token alone at frame end
      send_copy(2, 1, 0, 1'b1);          // copy in a fresh frame, no history
      wait_drained();
   endtask

   task automatic test_random_frames();
      int kind;
      for (int f = 0; f < 3; f++) begin
         send_literals($urandom_range(1, 8), 1'b0);
         for (int t = 0; t < 4; t++) begin
            kind = $urandom_range(0, 9);
            if (kind < 3) send_literals($urandom_range(1, 8), 1'b0);
            else if (kind < 7)
               send_copy($urandom_range(1, 6), $urandom_range(1, 40), 0, 1'b0);
            else if (kind < 9)
               send_copy(7, $urandom_range(1, 40), $urandom_range(0, 40), 1'b0);
            else send_item(8'($urandom), 1'($urandom_range(0, 1)));
         end
         send_item(8'h00, 1'b0);
         send_item(8'($urandom), 1'b1);
      end
   endtask

   task automatic test_backpressure();
      hold_req = 1;
      send_literals(16, 1'b0);
      send_copy(7, 3, 200, 1'b0);
      send_copy(5, 10, 0, 1'b1);
      wait_drained();
   endtask

   task automatic test_noise();
      for (int i = 0; i < 20; i++) send_item(8'($urandom), ($urandom_range(0, 7) == 0));
      send_item(8'h00, 1'b1);
   endtask

   initial begin
      wait (hold_req);
      @(posedge clock);
      hold_rsp <= 1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_rsp <= 0;
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 0;
         rsp_gap <= 0;
      end else if (hold_rsp) begin
         rsp_ready <= 0;
      end else if (rsp_gap > 0) begin
         rsp_ready <= 0;
         rsp_gap <= rsp_gap - 1;
      end else if ($urandom_range(0, 63) == 0) begin
         rsp_ready <= 0;
         rsp_gap <= $urandom_range(10, 40);
      end else if (rsp_ready && !rsp_valid) begin
         rsp_ready <= 1;
      end else begin
         rsp_ready <= ($urandom_range(0, 3) != 0) ||
                      ($urandom_range(0, 1) == 0 && rsp_ready);
      end
   end

   always @(posedge clock) begin
      group_type g;
      bit bad;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_groups.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("Unexpected result item: count %0d", rsp_byte_count);
         end else begin
            g = expected_groups.pop_front();
            bad = (rsp_byte_count != g.count) || (rsp_run_last != g.last) ||
                  (rsp_error_code != g.err);
            for (int i = 0; i < LANES; i++) if (ob[i] !== g.bytes[i]) bad = 1;
            if (bad) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("Mismatch: exp cnt %0d last %0d err %0d bytes %p",
                           g.count, g.last, g.err, g.bytes);
                  $display("          got cnt %0d last %0d err %0d bytes %p",
                           rsp_byte_count, rsp_run_last, rsp_error_code, ob);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > STALL_LIMIT && !timed_out) begin
         timed_out <= 1;
         $display("Simulation FAILED");
         $finish;
      end
   end

   initial begin
      wr_ptr = 0;
      decoded = 0;
      phase = PH_TOKEN;
      len_code = 0;
      off_hi = 0;
      off_lo = 0;
      lits_left = 0;
      repeat (7) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      test_directed();
      test_random_frames();
      test_backpressure();
      test_noise();
      wait_drained();
      repeat (100) @(posedge clock);
      if (mismatches == 0 && expected_groups.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end
endmodule

[sim.f]
rtl/lz77_pkg.sv
rtl/lz77_ram.sv
rtl/lz77_datapath.sv
rtl/lz77_ctrl.sv
rtl/lz77_token_decompressor.sv
test/tb.sv
